/* hdl/mkd_pkg.sv */
// Package for the Morse key decoder: widths, configuration and result types,
// the press classifier and the dichotomic character table.
// Has no dependencies; every other file of the block uses it.
`timescale 1ns / 1ps
`default_nettype none

package mkd_pkg;

  localparam int unsigned CountWidth = 8;
  localparam int unsigned LimitWidth = 8;
  localparam int unsigned CmpWidth   = (CountWidth > LimitWidth) ? CountWidth : LimitWidth;
  localparam int unsigned IndexWidth = 6;
  localparam int unsigned DepthWidth = 3;
  localparam int unsigned CharWidth  = 7;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned InDataWidth  = 8;
  localparam int unsigned OutDataWidth = 16;

  localparam logic [CountWidth-1:0] CountMax  = {CountWidth{1'b1}};
  localparam logic [IndexWidth-1:0] RootIndex = IndexWidth'(31);
  localparam logic [DepthWidth-1:0] MaxDepth  = DepthWidth'(5);

  localparam logic [64*8-1:0] CodeString =
      "5h4s#v3i#f#u##2e#l#r+##a#p#w#j1#6b=d/x#n#c#k#y#t7z#g#q#m8##o9#0#";

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_SHORT_LIMIT = 2'd0,
    CFG_LONG_LIMIT  = 2'd1,
    CFG_LETTER_GAP  = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CLASS_NONE  = 2'd0,
    CLASS_SHORT = 2'd1,
    CLASS_LONG  = 2'd2,
    CLASS_ERROR = 2'd3
  } press_class_e;

  typedef struct packed {
    logic [LimitWidth-1:0] short_limit;
    logic [LimitWidth-1:0] long_limit;
    logic [LimitWidth-1:0] letter_gap;
  } cfg_t;

  typedef struct packed {
    logic [1:0]           press_class;
    logic [CharWidth-1:0] letter_char;
    logic                 letter_valid;
  } result_t;

  function automatic press_class_e class_of(input logic [CountWidth-1:0] ticks,
                                            input cfg_t cfg);
    logic [CmpWidth-1:0] t;
    logic [CmpWidth-1:0] s;
    logic [CmpWidth-1:0] l;
    t = CmpWidth'(ticks);
    s = CmpWidth'(cfg.short_limit);
    l = CmpWidth'(cfg.long_limit);
    if (t == '0) begin
      return CLASS_NONE;
    end else if (t <= s) begin
      return CLASS_SHORT;
    end else if (t <= l) begin
      return CLASS_LONG;
    end else begin
      return CLASS_ERROR;
    end
  endfunction

  function automatic logic [CharWidth-1:0] code_char(input logic [IndexWidth-1:0] idx);
    logic [7:0] byte_val;
    byte_val = CodeString[(7'd63 - 7'(idx)) * 8 +: 8];
    return byte_val[CharWidth-1:0];
  endfunction

endpackage

`default_nettype wire

/* hdl/mkd_cfg_regs.sv */
// Configuration register file of the Morse key decoder: three timing limits.
// Depends on mkd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mkd_cfg_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  input  wire logic [mkd_pkg::CfgIdxWidth-1:0] cfg_index_i,
  input  wire logic [mkd_pkg::LimitWidth-1:0]  cfg_data_i,
  output mkd_pkg::cfg_t                        cfg_o
);

  mkd_pkg::cfg_t cfg_q;
  mkd_pkg::cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (mkd_pkg::cfg_idx_e'(cfg_index_i))
        mkd_pkg::CFG_SHORT_LIMIT: cfg_d.short_limit = cfg_data_i;
        mkd_pkg::CFG_LONG_LIMIT:  cfg_d.long_limit  = cfg_data_i;
        mkd_pkg::CFG_LETTER_GAP:  cfg_d.letter_gap  = cfg_data_i;
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_limit <= mkd_pkg::LimitWidth'(4);
      cfg_q.long_limit  <= mkd_pkg::LimitWidth'(12);
      cfg_q.letter_gap  <= mkd_pkg::LimitWidth'(15);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* hdl/mkd_decode_core.sv */
// Tick counters and dichotomic tree walker of the Morse key decoder.
// Updates its state on each accepted tick and computes that tick's result.
// Depends on mkd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mkd_decode_core (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    tick_i,
  input  wire logic    key_i,
  input  wire mkd_pkg::cfg_t cfg_i,
  output mkd_pkg::result_t result_o
);

  logic [mkd_pkg::CountWidth-1:0] press_q, press_d;
  logic [mkd_pkg::CountWidth-1:0] silence_q, silence_d;
  logic [mkd_pkg::IndexWidth-1:0] index_q, index_d, index_mid;
  logic [mkd_pkg::DepthWidth-1:0] depth_q, depth_d, depth_mid;
  logic                           key_prev_q;
  logic [mkd_pkg::IndexWidth-1:0] step;
  logic [mkd_pkg::CmpWidth-1:0]   silence_cmp;
  mkd_pkg::press_class_e          rel_class;
  logic                           emit;

  always_comb begin
    press_d   = press_q;
    silence_d = silence_q;
    index_mid = index_q;
    depth_mid = depth_q;
    rel_class = mkd_pkg::class_of(press_q, cfg_i);
    step      = mkd_pkg::IndexWidth'(5'd16 >> depth_q);
    if (key_i) begin
      if (press_q != mkd_pkg::CountMax) begin
        press_d = press_q + 1'b1;
      end
      silence_d = '0;
    end else begin
      if (key_prev_q && depth_q < mkd_pkg::MaxDepth) begin
        if (rel_class == mkd_pkg::CLASS_SHORT) begin
          index_mid = index_q - step;
          depth_mid = depth_q + 1'b1;
        end else if (rel_class == mkd_pkg::CLASS_LONG) begin
          index_mid = index_q + step;
          depth_mid = depth_q + 1'b1;
        end
      end
      press_d = '0;
      if (silence_q != mkd_pkg::CountMax) begin
        silence_d = silence_q + 1'b1;
      end
    end
    silence_cmp = mkd_pkg::CmpWidth'(silence_d);
    emit = (silence_cmp > mkd_pkg::CmpWidth'(cfg_i.letter_gap)) && (depth_mid != '0);
    index_d = emit ? mkd_pkg::RootIndex : index_mid;
    depth_d = emit ? '0 : depth_mid;
    result_o.letter_valid = emit;
    result_o.letter_char  = emit ? mkd_pkg::code_char(index_mid) : '0;
    result_o.press_class  = mkd_pkg::class_of(press_d, cfg_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_q    <= '0;
      silence_q  <= '0;
      index_q    <= mkd_pkg::RootIndex;
      depth_q    <= '0;
      key_prev_q <= 1'b0;
    end else if (tick_i) begin
      press_q    <= press_d;
      silence_q  <= silence_d;
      index_q    <= index_d;
      depth_q    <= depth_d;
      key_prev_q <= key_i;
    end
  end

endmodule

`default_nettype wire

/* hdl/morse_key_decoder.sv */
// A result is registered and appears on the master side in the cycle after its tick is accepted.
// Throughput: one tick per cycle; the single output register refills in the cycle
// it is taken, so input stalls only while an unread result is held back.
// Reset (rst_ni low, asynchronous) restores the default limits 4, 12 and 15,
// clears both counters, puts the tree index at its root and drops any held result.
`timescale 1ns / 1ps
`default_nettype none

module morse_key_decoder (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output      logic                              s_axis_tready,
  input  wire logic [mkd_pkg::InDataWidth-1:0]   s_axis_tdata,  // [0] key_pressed
  output      logic                              m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [0] letter_valid, [7:1] letter_char, [9:8] press_class, upper bits zero
  output      logic [mkd_pkg::OutDataWidth-1:0]  m_axis_tdata,
  input  wire logic                              cfg_valid_i,
  output      logic                              cfg_ready_o,
  input  wire logic [mkd_pkg::CfgIdxWidth-1:0]   cfg_index_i,
  input  wire logic [mkd_pkg::LimitWidth-1:0]    cfg_data_i
);

  mkd_pkg::cfg_t    cfg;
  mkd_pkg::result_t result;
  mkd_pkg::result_t out_q;
  logic             out_valid_q;
  logic             tick;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign tick          = s_axis_tvalid && s_axis_tready;

  mkd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  mkd_decode_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tick_i   (tick),
    .key_i    (s_axis_tdata[0]),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = mkd_pkg::OutDataWidth'(out_q);

endmodule

`default_nettype wire

/* hdl/mkd_checker.sv */
// Port-level checker for the Morse key decoder, bound to the top level.
// Depends on mkd_pkg and morse_key_decoder.
`timescale 1ns / 1ps
`default_nettype none

module mkd_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              s_axis_tvalid,
  input wire logic                              s_axis_tready,
  input wire logic                              m_axis_tvalid,
  input wire logic                              m_axis_tready,
  input wire logic [mkd_pkg::OutDataWidth-1:0]  m_axis_tdata
);

  // Every accepted tick yields a result in the next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted tick produced no result");

  // A stalled result holds its value.
  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Without a letter the character field is zero.
  a_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[7:1] == '0)
    else $error("character present without letter");

  // A letter is only emitted during silence, so no press is in progress.
  a_letter_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[9:8] == 2'd0)
    else $error("letter emitted while key pressed");

endmodule

bind morse_key_decoder mkd_checker u_mkd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

/* bench/tb.sv */
// Testbench for morse_key_decoder: tick streams with directed and random key
// timing, checked result by result against a behavioral model of the decoder.
// Depends on mkd_pkg and morse_key_decoder from the RTL.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned WatchdogCycles = 4000;
  localparam int unsigned HoldOffCycles  = 300;
  localparam int unsigned SymbolsMax     = 5;
  localparam int unsigned TicksPerPhase  = 40;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [mkd_pkg::InDataWidth-1:0]  s_axis_tdata = '0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [mkd_pkg::OutDataWidth-1:0] m_axis_tdata;
  logic                             cfg_valid_i = 1'b0;
  logic                             cfg_ready_o;
  logic [mkd_pkg::CfgIdxWidth-1:0]  cfg_index_i = '0;
  logic [mkd_pkg::LimitWidth-1:0]   cfg_data_i = '0;

  morse_key_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  string glyph_table = "5h4s#v3i#f#u##2e#l#r+##a#p#w#j1#6b=d/x#n#c#k#y#t7z#g#q#m8##o9#0#";

  logic [7:0] dot_limit = 8'd4;
  logic [7:0] dash_limit = 8'd12;
  logic [7:0] gap_limit = 8'd15;
  logic [7:0] press_count = '0;
  logic [7:0] quiet_count = '0;
  logic [5:0] tree_pos = 6'd31;
  logic [2:0] symbol_count = '0;
  logic       key_was_down = 1'b0;

  mkd_pkg::result_t tick_results_due[$];

  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  logic        hold_trigger = 1'b0;
  logic        hold_seen = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned ticks_sent = 0;
  int unsigned letters_seen = 0;

  function automatic mkd_pkg::press_class_e grade_press(input logic [7:0] ticks);
    if (ticks == '0) begin
      return mkd_pkg::CLASS_NONE;
    end else if (ticks <= dot_limit) begin
      return mkd_pkg::CLASS_SHORT;
    end else if (ticks <= dash_limit) begin
      return mkd_pkg::CLASS_LONG;
    end
    return mkd_pkg::CLASS_ERROR;
  endfunction

  task automatic decode_tick(input logic key);
    mkd_pkg::result_t      want;
    mkd_pkg::press_class_e grade;
    logic [5:0]            stride;
    byte                   glyph;
    want = '0;
    if (key) begin
      if (press_count != 8'hFF) press_count++;
      quiet_count = '0;
    end else begin
      if (key_was_down) begin
        grade = grade_press(press_count);
        if (symbol_count < SymbolsMax &&
            (grade == mkd_pkg::CLASS_SHORT || grade == mkd_pkg::CLASS_LONG)) begin
          stride = 6'd16 >> symbol_count;
          tree_pos = (grade == mkd_pkg::CLASS_SHORT) ? tree_pos - stride : tree_pos + stride;
          symbol_count++;
        end
      end
      press_count = '0;
      if (quiet_count != 8'hFF) quiet_count++;
    end
    key_was_down = key;
    if (quiet_count > gap_limit && symbol_count != 0) begin
      glyph = glyph_table[tree_pos];
      want.letter_valid = 1'b1;
      want.letter_char = glyph[6:0];
      tree_pos = 6'd31;
      symbol_count = '0;
    end
    want.press_class = grade_press(press_count);
    tick_results_due.push_back(want);
  endtask

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("MISMATCH at %0t: %s got %0d, expected %0d", $realtime, field, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      case (mkd_pkg::cfg_idx_e'(cfg_index_i))
        mkd_pkg::CFG_SHORT_LIMIT: dot_limit = cfg_data_i;
        mkd_pkg::CFG_LONG_LIMIT:  dash_limit = cfg_data_i;
        mkd_pkg::CFG_LETTER_GAP:  gap_limit = cfg_data_i;
        default: ;
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) decode_tick(s_axis_tdata[0]);
  end

  always @(posedge clk_i) begin
    mkd_pkg::result_t got;
    mkd_pkg::result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[$bits(mkd_pkg::result_t)-1:0];
      if (got.letter_valid) letters_seen++;
      if (tick_results_due.size() == 0) begin
        report_mismatch("unexpected transaction, letter_char", got.letter_char, 0);
      end else begin
        want = tick_results_due.pop_front();
        if (got.letter_valid != want.letter_valid)
          report_mismatch("letter_valid", got.letter_valid, want.letter_valid);
        if (got.letter_char != want.letter_char)
          report_mismatch("letter_char", got.letter_char, want.letter_char);
        if (got.press_class != want.press_class)
          report_mismatch("press_class", got.press_class, want.press_class);
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_trigger != hold_seen) begin
      hold_seen <= hold_trigger;
      hold_left <= HoldOffCycles;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WatchdogCycles) begin
      $display("Watchdog expired after %0d cycles without a transaction", WatchdogCycles);
      $display("morse_key_decoder regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_tick(input logic key);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= mkd_pkg::InDataWidth'(key);
    do @(posedge clk_i); while (!s_axis_tready);
    ticks_sent++;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic send_run(input logic key, input int unsigned count);
    repeat (count) send_tick(key);
  endtask

  task automatic put_reg(input mkd_pkg::cfg_idx_e idx, input logic [7:0] value);
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic write_config(input logic [7:0] dot, input logic [7:0] dash,
                              input logic [7:0] gap);
    cfg_valid_i <= 1'b1;
    put_reg(mkd_pkg::CFG_SHORT_LIMIT, dot);
    put_reg(mkd_pkg::CFG_LONG_LIMIT, dash);
    put_reg(mkd_pkg::CFG_LETTER_GAP, gap);
    put_reg(mkd_pkg::CFG_UNUSED, 8'($urandom_range(0, 255)));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic finish_phase();
    s_axis_tvalid <= 1'b0;
    while (tick_results_due.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  function automatic int unsigned pick_press_len();
    int unsigned dot_top;
    int unsigned err_low;
    int unsigned roll;
    dot_top = dot_limit;
    err_low = ((dot_limit > dash_limit) ? dot_limit : dash_limit) + 1;
    roll = $urandom_range(0, 99);
    if (roll < 15) return $urandom_range(err_low, err_low + 3);
    if (roll < 55 && dash_limit > dot_limit) return $urandom_range(dot_top + 1, dash_limit);
    return $urandom_range(1, dot_top);
  endfunction

  task automatic send_letter();
    int unsigned symbols;
    int unsigned k;
    symbols = $urandom_range(1, 6);
    for (k = 0; k < symbols; k++) begin
      send_run(1'b1, pick_press_len());
      if (k == symbols - 1) send_run(1'b0, $urandom_range(gap_limit + 1, gap_limit + 3));
      else send_run(1'b0, $urandom_range(1, gap_limit));
    end
  endtask

  task automatic test_directed_tree();
    write_config(8'd1, 8'd2, 8'd0);
    send_run(1'b1, 1);
    send_run(1'b0, 1);
    send_run(1'b1, 2);
    send_run(1'b0, 1);
    send_run(1'b1, 3);
    send_run(1'b0, 1);
    finish_phase();
    write_config(8'd1, 8'd2, 8'd1);
    repeat (6) begin
      send_run(1'b1, 1);
      send_run(1'b0, 1);
    end
    send_run(1'b0, 1);
    repeat (3) begin
      send_run(1'b1, 2);
      send_run(1'b0, 1);
    end
    send_run(1'b0, 1);
    finish_phase();
  endtask

  task automatic test_saturation();
    write_config(8'd255, 8'd255, 8'd254);
    send_run(1'b1, 257);
    send_run(1'b0, 257);
    finish_phase();
  endtask

  task automatic test_random_letters(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input logic [7:0] dot, input logic [7:0] dash,
                                     input logic [7:0] gap);
    int unsigned goal;
    write_config(dot, dash, gap);
    sender_idle_pct <= idle_pct;
    receiver_stall_pct <= stall_pct;
    goal = ticks_sent + TicksPerPhase;
    while (ticks_sent < goal) begin
      if ($urandom_range(0, 9) == 0) send_run(1'($urandom_range(0, 1)), $urandom_range(1, 4));
      else send_letter();
    end
    finish_phase();
  endtask

  task automatic test_output_hold_off();
    sender_idle_pct <= 0;
    receiver_stall_pct <= 0;
    hold_trigger <= ~hold_trigger;
    repeat (4) send_letter();
    finish_phase();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_tree();
    test_saturation();
    test_random_letters(0, 0, 8'd2, 8'd6, 8'd5);
    test_random_letters(82, 0, 8'd1, 8'd1, 8'd1);
    test_random_letters(0, 82, 8'd5, 8'd3, 8'd8);
    test_random_letters(36, 36, 8'($urandom_range(1, 6)), 8'($urandom_range(1, 12)),
                        8'($urandom_range(1, 10)));
    test_output_hold_off();
    repeat (5) @(posedge clk_i);
    $display("Covered %0d key ticks and %0d decoded letters: tree extremes, saturated counters,",
             ticks_sent, letters_seen);
    $display("four idle patterns and a long output hold-off; %0d mismatches.", mismatches);
    if (mismatches == 0) begin
      $display("morse_key_decoder regression: pass");
    end else begin
      $display("morse_key_decoder regression: fail");
    end
    $finish;
  end

endmodule
